/* design/protobuf_field_scanner_macros.svh */
// assertion macros shared by the protobuf field scanner design files
// no dependencies; included by the files that carry concurrent assertions
`ifndef PROTOBUF_FIELD_SCANNER_MACROS_SVH
`define PROTOBUF_FIELD_SCANNER_MACROS_SVH

// plain property, checked on every rising edge outside reset
`define PBFS_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// same-cycle implication, checked on every rising edge outside reset
`define PBFS_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

/* design/pbfs_pkg.sv */
// types, codes and sizing constants of the protobuf field scanner
// no dependencies; imported by every module of the block
package pbfs_pkg;

  localparam int NUM_KEYS       = 4;
  localparam int LENGTH_BITS    = 32;
  localparam int KEY_ID_BITS    = 29;
  localparam int NUM_CFG_REGS   = 4;
  localparam int CFG_INDEX_BITS = $clog2(NUM_CFG_REGS);
  localparam int TAG_BITS       = 32;
  localparam int VALUE_BITS     = 64;
  localparam int SHIFT_BITS     = $clog2(VALUE_BITS);
  localparam int SC_BITS        = 7;
  localparam int KEY_IDX_BITS   = 2;

  // result queue, depth must be a power of two
  localparam int RES_DEPTH    = 4;
  localparam int RES_PTR_BITS = $clog2(RES_DEPTH);
  localparam int RES_CNT_BITS = $clog2(RES_DEPTH + 1);

  localparam logic [1:0] KIND_VALUE   = 2'd0;
  localparam logic [1:0] KIND_PAYLOAD = 2'd1;
  localparam logic [1:0] KIND_DONE    = 2'd2;
  localparam logic [1:0] KIND_ERROR   = 2'd3;

  localparam logic [2:0] WT_VARINT  = 3'd0;
  localparam logic [2:0] WT_FIXED64 = 3'd1;
  localparam logic [2:0] WT_BYTES   = 3'd2;
  localparam logic [2:0] WT_FIXED32 = 3'd5;

  localparam logic [2:0] ERR_OVERFLOW     = 3'd0;
  localparam logic [2:0] ERR_ZERO_CONT    = 3'd1;
  localparam logic [2:0] ERR_UNKNOWN_TYPE = 3'd2;
  localparam logic [2:0] ERR_TRUNCATED    = 3'd3;
  localparam logic [2:0] ERR_TAG_TOO_LONG = 3'd4;

  typedef enum logic [2:0] {
    PH_TAG,
    PH_VARINT,
    PH_FIXED,
    PH_LENGTH,
    PH_PAYLOAD
  } phase_e;

  typedef logic [NUM_CFG_REGS-1:0][KEY_ID_BITS-1:0] key_ids_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_message;
  } msg_beat_t;

  typedef struct packed {
    logic [1:0]              kind;
    logic [KEY_IDX_BITS-1:0] key_index;
    logic [2:0]              wire_type;
    logic [VALUE_BITS-1:0]   field_value;
    logic [7:0]              payload_byte;
    logic [2:0]              error_code;
    logic                    last;
  } res_beat_t;

  // up to two results caused by one message byte, packed from beat 0
  typedef struct packed {
    logic [1:0]            count;
    res_beat_t [1:0]       beat;
  } step_res_t;

endpackage

/* design/pbfs_decoder.sv */
// scan state and per-byte decode of the protobuf field scanner
// depends on pbfs_pkg and protobuf_field_scanner_macros.svh
`include "protobuf_field_scanner_macros.svh"

module pbfs_decoder (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  pbfs_pkg::msg_beat_t beat,
  input  pbfs_pkg::key_ids_t  key_ids,
  output pbfs_pkg::step_res_t res
);
  import pbfs_pkg::*;

  typedef enum logic [1:0] {
    VI_MORE,
    VI_DONE,
    VI_ERR
  } vi_status_e;

  typedef struct packed {
    vi_status_e            status;
    logic [2:0]            code;
    logic [SC_BITS-1:0]    sc;
    logic [VALUE_BITS-1:0] acc;
  } vi_res_t;

  // one byte of a varint of at most width bits
  function automatic vi_res_t varint_step(input logic [7:0] b,
                                          input logic [SC_BITS-1:0] sc,
                                          input logic [VALUE_BITS-1:0] acc,
                                          input logic [SC_BITS-1:0] width,
                                          input logic [2:0] too_long);
    logic [SC_BITS-1:0] room;
    logic [6:0]         low7;
    logic [SC_BITS:0]   sc_sum;
    vi_res_t            r;
    room     = width - sc;
    low7     = b[6:0];
    sc_sum   = {1'b0, sc} + (SC_BITS+1)'(7);
    r.acc    = acc | (VALUE_BITS'(low7) << sc[SHIFT_BITS-1:0]);
    r.sc     = sc_sum[SC_BITS-1:0];
    r.code   = ERR_OVERFLOW;
    r.status = VI_MORE;
    if (room < SC_BITS'(8) && (low7 >> room[2:0]) != 7'd0) begin
      r.status = VI_ERR;
      r.code   = ERR_OVERFLOW;
    end else if (b == 8'd0 && sc != '0) begin
      r.status = VI_ERR;
      r.code   = ERR_ZERO_CONT;
    end else if (!b[7]) begin
      r.status = VI_DONE;
    end else if (sc_sum >= {1'b0, width}) begin
      r.status = VI_ERR;
      r.code   = too_long;
    end
    return r;
  endfunction

  phase_e                   phase, phase_next;
  logic [SC_BITS-1:0]       sc, sc_next;
  logic [VALUE_BITS-1:0]    acc, acc_next;
  logic [LENGTH_BITS-1:0]   bytes_left, bytes_left_next;
  logic [2:0]               cur_type, cur_type_next;
  logic                     cur_hit, cur_hit_next;
  logic [KEY_IDX_BITS-1:0]  cur_idx, cur_idx_next;
  logic                     error_hold, error_hold_next;

  logic [SC_BITS-1:0]       vi_width;
  logic [2:0]               vi_too_long;
  vi_res_t                  vi;
  logic                     tag_hit;
  logic [KEY_IDX_BITS-1:0]  tag_idx;
  logic [VALUE_BITS-1:0]    acc_fixed;
  logic [LENGTH_BITS-1:0]   bytes_dec;
  logic [LENGTH_BITS-1:0]   len;
  res_beat_t                prim, term;
  logic                     prim_valid, term_valid;
  logic                     err;
  logic [2:0]               err_code;
  logic                     clear;

  // shared varint unit, its width set by the field part being scanned
  always_comb begin
    case (phase)
      PH_VARINT: begin
        vi_width    = SC_BITS'(VALUE_BITS);
        vi_too_long = ERR_OVERFLOW;
      end
      PH_LENGTH: begin
        vi_width    = SC_BITS'(LENGTH_BITS);
        vi_too_long = ERR_OVERFLOW;
      end
      default: begin
        vi_width    = SC_BITS'(TAG_BITS);
        vi_too_long = ERR_TAG_TOO_LONG;
      end
    endcase
    vi = varint_step(beat.data_byte, sc, acc, vi_width, vi_too_long);
  end

  // lowest-indexed nonzero key id that equals the tag's field id
  always_comb begin
    tag_hit = 1'b0;
    tag_idx = '0;
    for (int k = NUM_KEYS - 1; k >= 0; k--) begin
      if (key_ids[k] != '0 && key_ids[k] == vi.acc[TAG_BITS-1:3]) begin
        tag_hit = 1'b1;
        tag_idx = KEY_IDX_BITS'(k);
      end
    end
  end

  assign acc_fixed = acc | (VALUE_BITS'(beat.data_byte) << {sc[SHIFT_BITS-1:3], 3'b000});
  assign bytes_dec = bytes_left - LENGTH_BITS'(1);
  assign len       = vi.acc[LENGTH_BITS-1:0];

  always_comb begin
    phase_next      = phase;
    sc_next         = sc;
    acc_next        = acc;
    bytes_left_next = bytes_left;
    cur_type_next   = cur_type;
    cur_hit_next    = cur_hit;
    cur_idx_next    = cur_idx;
    error_hold_next = error_hold;
    prim            = '0;
    term            = '0;
    prim_valid      = 1'b0;
    term_valid      = 1'b0;
    err             = 1'b0;
    err_code        = ERR_OVERFLOW;
    clear           = 1'b0;

    if (step) begin
      if (error_hold) begin
        clear = beat.end_of_message;
      end else begin
        case (phase)
          PH_VARINT: begin
            case (vi.status)
              VI_DONE: begin
                prim_valid        = cur_hit;
                prim.kind         = KIND_VALUE;
                prim.key_index    = cur_idx;
                prim.wire_type    = WT_VARINT;
                prim.field_value  = vi.acc;
                phase_next        = PH_TAG;
                sc_next           = '0;
                acc_next          = '0;
                bytes_left_next   = '0;
              end
              VI_MORE: begin
                acc_next = vi.acc;
                sc_next  = vi.sc;
              end
              default: begin
                err      = 1'b1;
                err_code = vi.code;
              end
            endcase
          end
          PH_FIXED: begin
            acc_next        = acc_fixed;
            sc_next         = sc + SC_BITS'(8);
            bytes_left_next = bytes_dec;
            if (bytes_dec == '0) begin
              prim_valid       = cur_hit;
              prim.kind        = KIND_VALUE;
              prim.key_index   = cur_idx;
              prim.wire_type   = cur_type;
              prim.field_value = acc_fixed;
              phase_next       = PH_TAG;
              sc_next          = '0;
              acc_next         = '0;
              bytes_left_next  = '0;
            end
          end
          PH_LENGTH: begin
            case (vi.status)
              VI_DONE: begin
                prim_valid       = cur_hit;
                prim.kind        = KIND_VALUE;
                prim.key_index   = cur_idx;
                prim.wire_type   = WT_BYTES;
                prim.field_value = vi.acc;
                phase_next       = (len != '0) ? PH_PAYLOAD : PH_TAG;
                sc_next          = '0;
                acc_next         = '0;
                bytes_left_next  = len;
              end
              VI_MORE: begin
                acc_next = vi.acc;
                sc_next  = vi.sc;
              end
              default: begin
                err      = 1'b1;
                err_code = vi.code;
              end
            endcase
          end
          PH_PAYLOAD: begin
            prim_valid        = cur_hit;
            prim.kind         = KIND_PAYLOAD;
            prim.key_index    = cur_idx;
            prim.wire_type    = WT_BYTES;
            prim.payload_byte = beat.data_byte;
            bytes_left_next   = bytes_dec;
            if (bytes_dec == '0) begin
              phase_next = PH_TAG;
              sc_next    = '0;
              acc_next   = '0;
            end
          end
          default: begin
            phase_next = PH_TAG;
            case (vi.status)
              VI_DONE: begin
                cur_type_next   = vi.acc[2:0];
                cur_hit_next    = tag_hit;
                cur_idx_next    = tag_idx;
                sc_next         = '0;
                acc_next        = '0;
                bytes_left_next = '0;
                case (vi.acc[2:0])
                  WT_VARINT: phase_next = PH_VARINT;
                  WT_FIXED64: begin
                    phase_next      = PH_FIXED;
                    bytes_left_next = LENGTH_BITS'(8);
                  end
                  WT_FIXED32: begin
                    phase_next      = PH_FIXED;
                    bytes_left_next = LENGTH_BITS'(4);
                  end
                  WT_BYTES: phase_next = PH_LENGTH;
                  default: begin
                    err      = 1'b1;
                    err_code = ERR_UNKNOWN_TYPE;
                  end
                endcase
              end
              VI_MORE: begin
                acc_next = vi.acc;
                sc_next  = vi.sc;
              end
              default: begin
                err      = 1'b1;
                err_code = vi.code;
              end
            endcase
          end
        endcase

        if (err) begin
          prim_valid      = 1'b1;
          prim            = '0;
          prim.kind       = KIND_ERROR;
          prim.error_code = err_code;
          error_hold_next = 1'b1;
        end

        // message end: exactly one terminal beat unless an error was just raised
        if (beat.end_of_message) begin
          if (!err) begin
            term_valid = 1'b1;
            if (phase_next == PH_TAG && sc_next == '0) begin
              term.kind = KIND_DONE;
            end else begin
              term.kind       = KIND_ERROR;
              term.error_code = ERR_TRUNCATED;
            end
          end
          clear = 1'b1;
        end
      end
    end

    if (clear) begin
      phase_next      = PH_TAG;
      sc_next         = '0;
      acc_next        = '0;
      bytes_left_next = '0;
      cur_type_next   = '0;
      cur_hit_next    = 1'b0;
      cur_idx_next    = '0;
      error_hold_next = 1'b0;
    end
  end

  // pack results from beat 0 and mark the final one
  always_comb begin
    res = '0;
    case ({prim_valid, term_valid})
      2'b11: begin
        res.count        = 2'd2;
        res.beat[0]      = prim;
        res.beat[1]      = term;
        res.beat[1].last = 1'b1;
      end
      2'b10: begin
        res.count        = 2'd1;
        res.beat[0]      = prim;
        res.beat[0].last = 1'b1;
      end
      2'b01: begin
        res.count        = 2'd1;
        res.beat[0]      = term;
        res.beat[0].last = 1'b1;
      end
      default: res.count = 2'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_TAG;
      sc         <= '0;
      acc        <= '0;
      bytes_left <= '0;
      cur_type   <= '0;
      cur_hit    <= 1'b0;
      cur_idx    <= '0;
      error_hold <= 1'b0;
    end else begin
      phase      <= phase_next;
      sc         <= sc_next;
      acc        <= acc_next;
      bytes_left <= bytes_left_next;
      cur_type   <= cur_type_next;
      cur_hit    <= cur_hit_next;
      cur_idx    <= cur_idx_next;
      error_hold <= error_hold_next;
    end
  end

  `PBFS_ASSERT_IMP(a_hold_silent, clk, rst, step && error_hold, res.count == 2'd0, "byte produced a result while an error was held")
  `PBFS_ASSERT_IMP(a_second_terminal, clk, rst, res.count == 2'd2, res.beat[1].kind == KIND_DONE || res.beat[1].kind == KIND_ERROR, "second result of a byte is not a terminal beat")
  `PBFS_ASSERT_IMP(a_no_result_idle, clk, rst, !step, res.count == 2'd0, "result produced without a byte")

endmodule

/* design/pbfs_result_fifo.sv */
// small result queue of the protobuf field scanner, up to two writes and one read per cycle
// depends on pbfs_pkg and protobuf_field_scanner_macros.svh
`include "protobuf_field_scanner_macros.svh"

module pbfs_result_fifo (
  input  logic                clk,
  input  logic                rst,
  input  pbfs_pkg::step_res_t push,
  output logic                room,
  output logic                res_valid,
  input  logic                res_ready,
  output pbfs_pkg::res_beat_t res_beat
);
  import pbfs_pkg::*;

  res_beat_t                entries [RES_DEPTH];
  logic [RES_PTR_BITS-1:0]  head, tail, tail_plus1;
  logic [RES_CNT_BITS-1:0]  count;
  logic                     pop;

  assign pop        = res_valid && res_ready;
  assign tail_plus1 = tail + RES_PTR_BITS'(1);
  assign res_valid  = count != '0;
  assign res_beat   = entries[head];
  // room for the worst case of two results from one byte
  assign room       = count <= RES_CNT_BITS'(RES_DEPTH - 2);

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (pop) begin
        head <= head + RES_PTR_BITS'(1);
      end
      tail  <= tail + RES_PTR_BITS'(push.count);
      count <= count + RES_CNT_BITS'(push.count) - RES_CNT_BITS'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      entries[tail] <= push.beat[0];
    end
    if (push.count == 2'd2) begin
      entries[tail_plus1] <= push.beat[1];
    end
  end

  `PBFS_ASSERT(a_count_bound, clk, rst, count <= RES_CNT_BITS'(RES_DEPTH), "result queue overfilled")
  `PBFS_ASSERT_IMP(a_push_room, clk, rst, push.count != 2'd0, room, "results pushed without room for two")

endmodule

/* design/protobuf_field_scanner.sv */
// top level of the protobuf field scanner: key registers, input stage, decoder and result queue
// depends on pbfs_pkg, pbfs_decoder and pbfs_result_fifo
//
// Streaming protobuf wire-format scanner. One message byte arrives per msg beat,
// with end_of_message on the final byte. Each tag varint (up to 32 bits) is split
// into a field id and a wire type; the id is compared against the four key id
// registers (zero means unused, lowest index wins). A matched field gives a value
// beat: the varint, the little-endian fixed32/fixed64 value or the length of a
// bytes field, and a matched bytes field then gives one payload beat per byte.
// Unmatched fields are skipped by type. Every message ends in exactly one
// terminal beat, message done or an error; after an error all bytes up to the end
// of the message are swallowed. Key ids are written through cfg_we/cfg_index/
// cfg_data; the user must do so only while the block is idle, which the block
// itself does not enforce. Timing: a byte is taken into an input register,
// decoded by one pass through the decoder once the queue has room for two beats,
// and written into a four-entry result queue whose head drives res_beat. The
// block takes one byte per cycle as long as the result side takes one beat per
// cycle; a byte that gives a matched field's beat and is also the last byte of a
// message yields two beats, and the input stalls whenever the queue cannot take
// two more beats.

module protobuf_field_scanner (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   msg_valid,
  output logic                                   msg_ready,
  input  pbfs_pkg::msg_beat_t                    msg_beat,
  output logic                                   res_valid,
  input  logic                                   res_ready,
  output pbfs_pkg::res_beat_t                    res_beat,
  input  logic                                   cfg_we,
  input  logic [pbfs_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
  input  logic [pbfs_pkg::KEY_ID_BITS-1:0]       cfg_data
);
  import pbfs_pkg::*;

  key_ids_t  key_ids;
  logic      s1_valid;
  msg_beat_t s1_beat;
  logic      s1_go;
  logic      fifo_room;
  step_res_t step_res;

  // key id registers, zero after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      key_ids <= '0;
    end else if (cfg_we) begin
      key_ids[cfg_index] <= cfg_data;
    end
  end

  // input stage: the held byte moves on once the queue has room for two beats
  assign s1_go     = s1_valid && fifo_room;
  assign msg_ready = !s1_valid || s1_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (msg_ready) begin
      s1_valid <= msg_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (msg_valid && msg_ready) begin
      s1_beat <= msg_beat;
    end
  end

  // field scan state and per-byte decode
  pbfs_decoder u_decoder (
    .clk     (clk),
    .rst     (rst),
    .step    (s1_go),
    .beat    (s1_beat),
    .key_ids (key_ids),
    .res     (step_res)
  );

  // result beats wait here, decoupling the output handshake from decode
  pbfs_result_fifo u_result_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (step_res),
    .room      (fifo_room),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_beat  (res_beat)
  );

endmodule

/* test/pbfs_monitor.sv */
`timescale 1ns / 100ps
// result checker for the protobuf field scanner: snoops key writes, decodes every accepted byte
// and compares each result beat in order; depends on pbfs_pkg only
module pbfs_monitor (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                msg_valid,
  input  logic                                msg_ready,
  input  pbfs_pkg::msg_beat_t                 msg_beat,
  input  logic                                res_valid,
  input  logic                                res_ready,
  input  pbfs_pkg::res_beat_t                 res_beat,
  input  logic                                cfg_we,
  input  logic [pbfs_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [pbfs_pkg::KEY_ID_BITS-1:0]    cfg_data,
  output int                                  fail_count,
  output int                                  pending,
  output int                                  n_value,
  output int                                  n_payload,
  output int                                  n_done,
  output int                                  n_error
);
  import pbfs_pkg::*;

  localparam logic [2:0] NO_KEY = 3'd4;

  typedef enum logic [1:0] {
    VB_MORE,
    VB_DONE,
    VB_FAULT
  } vb_e;

  logic [KEY_ID_BITS-1:0] key_ids [NUM_CFG_REGS];
  phase_e                 scan_ph;
  logic [SC_BITS-1:0]     shift_n;
  logic [VALUE_BITS-1:0]  acc;
  logic [LENGTH_BITS-1:0] left;
  logic [2:0]             cur_wt;
  logic [2:0]             cur_key;
  logic                   hold;
  res_beat_t              due_beats[$];
  int                     fails;
  int                     seen [4];

  function automatic void clear_scan();
    scan_ph = PH_TAG;
    shift_n = '0;
    acc     = '0;
    left    = '0;
    cur_wt  = '0;
    cur_key = NO_KEY;
    hold    = 1'b0;
  endfunction

  function automatic void back_to_tag();
    scan_ph = PH_TAG;
    shift_n = '0;
    acc     = '0;
    left    = '0;
  endfunction

  function automatic void put_beat(input logic [1:0] kind, input logic [2:0] idx,
                                   input logic [2:0] wt, input logic [63:0] val,
                                   input logic [7:0] pb, input logic [2:0] ec);
    res_beat_t r;
    r.kind         = kind;
    r.key_index    = idx[1:0];
    r.wire_type    = wt;
    r.field_value  = val;
    r.payload_byte = pb;
    r.error_code   = ec;
    r.last         = 1'b0;
    due_beats.push_back(r);
  endfunction

  // one varint byte against a width limit; code carries the error on a fault
  function automatic vb_e take_varint_byte(input logic [7:0] b, input int unsigned width,
                                           input logic [2:0] long_code,
                                           output logic [2:0] code);
    logic [6:0]  low7;
    int unsigned room;
    low7 = b[6:0];
    room = width - shift_n;
    code = ERR_OVERFLOW;
    if (room < 8 && (low7 >> room) != 0) return VB_FAULT;
    if (b == 8'h00 && shift_n != 0) begin
      code = ERR_ZERO_CONT;
      return VB_FAULT;
    end
    acc = acc | (64'(low7) << shift_n);
    if (!b[7]) return VB_DONE;
    shift_n = shift_n + SC_BITS'(7);
    if (shift_n >= width) begin
      code = long_code;
      return VB_FAULT;
    end
    return VB_MORE;
  endfunction

  // works out the result beats that one message byte causes
  task automatic scan_byte(input logic [7:0] b, input logic eom);
    int                     first_new;
    int                     k;
    logic                   fault;
    logic [2:0]             code;
    vb_e                    vb;
    logic [63:0]            len;
    logic [KEY_ID_BITS-1:0] id;
    res_beat_t              tail;
    first_new = due_beats.size();
    fault     = 1'b0;
    code      = '0;
    if (hold) begin
      if (eom) clear_scan();
      return;
    end
    case (scan_ph)
      PH_VARINT: begin
        vb = take_varint_byte(b, VALUE_BITS, ERR_OVERFLOW, code);
        if (vb == VB_DONE) begin
          if (cur_key != NO_KEY) put_beat(KIND_VALUE, cur_key, WT_VARINT, acc, '0, '0);
          back_to_tag();
        end else if (vb == VB_FAULT) begin
          fault = 1'b1;
        end
      end
      PH_FIXED: begin
        acc     = acc | (64'(b) << shift_n[5:0]);
        shift_n = shift_n + SC_BITS'(8);
        left    = left - LENGTH_BITS'(1);
        if (left == 0) begin
          if (cur_key != NO_KEY) put_beat(KIND_VALUE, cur_key, cur_wt, acc, '0, '0);
          back_to_tag();
        end
      end
      PH_LENGTH: begin
        vb = take_varint_byte(b, LENGTH_BITS, ERR_OVERFLOW, code);
        if (vb == VB_DONE) begin
          len = acc;
          if (cur_key != NO_KEY) put_beat(KIND_VALUE, cur_key, WT_BYTES, len, '0, '0);
          back_to_tag();
          if (len != 0) begin
            scan_ph = PH_PAYLOAD;
            left    = len[LENGTH_BITS-1:0];
          end
        end else if (vb == VB_FAULT) begin
          fault = 1'b1;
        end
      end
      PH_PAYLOAD: begin
        if (cur_key != NO_KEY) put_beat(KIND_PAYLOAD, cur_key, WT_BYTES, '0, b, '0);
        left = left - LENGTH_BITS'(1);
        if (left == 0) back_to_tag();
      end
      default: begin
        scan_ph = PH_TAG;
        vb = take_varint_byte(b, TAG_BITS, ERR_TAG_TOO_LONG, code);
        if (vb == VB_DONE) begin
          id      = acc[31:3];
          cur_wt  = acc[2:0];
          cur_key = NO_KEY;
          for (k = 0; k < NUM_KEYS; k++) begin
            if (cur_key == NO_KEY && key_ids[k] != '0 && key_ids[k] == id) cur_key = 3'(k);
          end
          back_to_tag();
          case (cur_wt)
            WT_VARINT: scan_ph = PH_VARINT;
            WT_FIXED64: begin
              scan_ph = PH_FIXED;
              left    = LENGTH_BITS'(8);
            end
            WT_FIXED32: begin
              scan_ph = PH_FIXED;
              left    = LENGTH_BITS'(4);
            end
            WT_BYTES: scan_ph = PH_LENGTH;
            default: begin
              fault = 1'b1;
              code  = ERR_UNKNOWN_TYPE;
            end
          endcase
        end else if (vb == VB_FAULT) begin
          fault = 1'b1;
        end
      end
    endcase
    if (fault) begin
      put_beat(KIND_ERROR, '0, '0, '0, '0, code);
      hold = 1'b1;
    end
    if (eom) begin
      if (!hold) begin
        if (scan_ph == PH_TAG && shift_n == 0) put_beat(KIND_DONE, '0, '0, '0, '0, '0);
        else put_beat(KIND_ERROR, '0, '0, '0, '0, ERR_TRUNCATED);
      end
      clear_scan();
    end
    if (due_beats.size() > first_new) begin
      tail      = due_beats.pop_back();
      tail.last = 1'b1;
      due_beats.push_back(tail);
    end
  endtask

  function automatic string beat_text(input res_beat_t r);
    return $sformatf("kind %0d key %0d type %0d value %h byte %h code %0d last %0b",
                     r.kind, r.key_index, r.wire_type, r.field_value, r.payload_byte,
                     r.error_code, r.last);
  endfunction

  always @(posedge clk) begin
    res_beat_t want;
    if (rst) begin
      for (int i = 0; i < NUM_CFG_REGS; i++) key_ids[i] = '0;
      clear_scan();
      due_beats.delete();
      fails = 0;
      for (int i = 0; i < 4; i++) seen[i] = 0;
    end else begin
      if (cfg_we) key_ids[cfg_index] = cfg_data;
      if (msg_valid && msg_ready) scan_byte(msg_beat.data_byte, msg_beat.end_of_message);
      if (res_valid && res_ready) begin
        if (due_beats.size() == 0) begin
          fails++;
          if (fails <= 10) $display("%0t unexpected result beat: %s", $time, beat_text(res_beat));
        end else begin
          want = due_beats.pop_front();
          if (res_beat.kind !== want.kind || res_beat.key_index !== want.key_index ||
              res_beat.wire_type !== want.wire_type ||
              res_beat.field_value !== want.field_value ||
              res_beat.payload_byte !== want.payload_byte ||
              res_beat.error_code !== want.error_code || res_beat.last !== want.last) begin
            fails++;
            if (fails <= 10)
              $display("%0t result mismatch\n  expected %s\n  got      %s", $time,
                       beat_text(want), beat_text(res_beat));
          end else begin
            seen[want.kind]++;
          end
        end
      end
    end
    fail_count <= fails;
    pending    <= due_beats.size();
    n_value    <= seen[KIND_VALUE];
    n_payload  <= seen[KIND_PAYLOAD];
    n_done     <= seen[KIND_DONE];
    n_error    <= seen[KIND_ERROR];
  end

endmodule

/* test/tb_top.sv */
`timescale 1ns / 100ps
// top of the protobuf field scanner testbench: clock, reset, key settings and message stimulus
// depends on pbfs_pkg, protobuf_field_scanner and pbfs_monitor
module tb_top;
  import pbfs_pkg::*;

  localparam logic [KEY_ID_BITS-1:0] KEY_MAX = '1;
  localparam int KEY_SETS      = 6;
  localparam int BYTES_PER_SET = 185;

  logic                      clk;
  logic                      rst;
  logic                      msg_valid;
  logic                      msg_ready;
  msg_beat_t                 msg_beat;
  logic                      res_valid;
  logic                      res_ready;
  res_beat_t                 res_beat;
  logic                      cfg_we;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [KEY_ID_BITS-1:0]    cfg_data;

  int fail_count, pending, n_value, n_payload, n_done, n_error;

  // bytes of the message being built, and the key ids currently loaded
  logic [7:0]             msg_bytes[$];
  logic [KEY_ID_BITS-1:0] keys_now [NUM_CFG_REGS];
  bit                     quiet;
  int                     bytes_sent;
  int                     msgs_sent;

  protobuf_field_scanner uut (
    .clk       (clk),
    .rst       (rst),
    .msg_valid (msg_valid),
    .msg_ready (msg_ready),
    .msg_beat  (msg_beat),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_beat  (res_beat),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  pbfs_monitor mon (
    .clk        (clk),
    .rst        (rst),
    .msg_valid  (msg_valid),
    .msg_ready  (msg_ready),
    .msg_beat   (msg_beat),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res_beat   (res_beat),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending),
    .n_value    (n_value),
    .n_payload  (n_payload),
    .n_done     (n_done),
    .n_error    (n_error)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // result side stalls at random with a chance of 11 in 100, never during the quiet stretch
  always @(posedge clk) begin
    res_ready <= quiet || ($urandom_range(0, 99) >= 11);
  end

  // hard stop in case the block hangs
  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

  // one byte beat; random idle cycles in front of it unless in the quiet stretch
  task automatic send_byte(input logic [7:0] b, input logic eom);
    while (!quiet && $urandom_range(0, 99) < 11) begin
      msg_valid <= 1'b0;
      @(posedge clk);
    end
    msg_valid <= 1'b1;
    msg_beat  <= '{data_byte: b, end_of_message: eom};
    @(posedge clk);
    while (!msg_ready) @(posedge clk);
    bytes_sent++;
  endtask

  // sends the built message with end_of_message on its final byte
  task automatic send_msg();
    int i;
    for (i = 0; i < msg_bytes.size(); i++) send_byte(msg_bytes[i], i == msg_bytes.size() - 1);
    msg_bytes.delete();
    msgs_sent++;
  endtask

  // lowers valid, waits for every expected result beat, then lets the pipeline settle
  task automatic drain();
    msg_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_keys();
    int i;
    for (i = 0; i < NUM_CFG_REGS; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= CFG_INDEX_BITS'(i);
      cfg_data  <= keys_now[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  // least significant group first, continuation bit on all but the final byte
  task automatic add_varint(input logic [63:0] v);
    logic [63:0] rest;
    logic [7:0]  b;
    rest = v;
    do begin
      b    = {1'b0, rest[6:0]};
      rest = rest >> 7;
      if (rest != 0) b[7] = 1'b1;
      msg_bytes.push_back(b);
    end while (rest != 0);
  endtask

  task automatic add_tag(input logic [KEY_ID_BITS-1:0] id, input logic [2:0] wt);
    add_varint({32'd0, id, wt});
  endtask

  // varint bytes with the continuation bit set and random low bits
  task automatic add_cont_bytes(input int unsigned n);
    int unsigned i;
    for (i = 0; i < n; i++) msg_bytes.push_back({1'b1, 7'($urandom)});
  endtask

  task automatic add_random_bytes(input int unsigned n);
    int unsigned i;
    for (i = 0; i < n; i++) msg_bytes.push_back(8'($urandom));
  endtask

  function automatic logic [63:0] rand_bits(input int unsigned bits);
    logic [63:0] v;
    v = {$urandom, $urandom};
    if (bits < 64) v = v & ((64'd1 << bits) - 64'd1);
    return v;
  endfunction

  // mostly loaded keys, so that fields match; otherwise zero, the largest id or strays
  function automatic logic [KEY_ID_BITS-1:0] pick_id();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel < 6) return keys_now[$urandom_range(0, NUM_CFG_REGS - 1)];
    if (sel == 6) return '0;
    if (sel == 7) return KEY_MAX;
    if (sel == 8) return KEY_ID_BITS'($urandom_range(1, 40));
    return KEY_ID_BITS'($urandom);
  endfunction

  // one of the wire types 3, 4, 6 and 7
  function automatic logic [2:0] pick_bad_type();
    logic [2:0] t;
    t = 3'($urandom_range(3, 6));
    return (t >= WT_FIXED32) ? t + 3'd1 : t;
  endfunction

  task automatic add_field();
    logic [KEY_ID_BITS-1:0] id;
    logic [63:0]            v;
    int unsigned            sel;
    int unsigned            len;
    int unsigned            i;
    id  = pick_id();
    sel = $urandom_range(0, 19);
    v   = ($urandom_range(0, 7) == 0) ? '1 : rand_bits($urandom_range(0, 64));
    if (sel < 6) begin
      add_tag(id, WT_VARINT);
      add_varint(v);
    end else if (sel < 10) begin
      add_tag(id, WT_FIXED64);
      for (i = 0; i < 8; i++) msg_bytes.push_back(v[8*i +: 8]);
    end else if (sel < 14) begin
      add_tag(id, WT_FIXED32);
      for (i = 0; i < 4; i++) msg_bytes.push_back(v[8*i +: 8]);
    end else if (sel < 19) begin
      // mostly short bytes fields, now and then a longer one, zero length included
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 24) : $urandom_range(0, 6);
      add_tag(id, WT_BYTES);
      add_varint(64'(len));
      add_random_bytes(len);
    end else begin
      add_tag(id, pick_bad_type());
    end
  endtask

  // a field that must end the scan in an error
  task automatic add_broken();
    logic [KEY_ID_BITS-1:0] id;
    int unsigned            sel;
    id  = pick_id();
    sel = $urandom_range(0, 6);
    case (sel)
      0: begin
        // tag continues past 32 bits
        add_cont_bytes(4);
        msg_bytes.push_back(8'h80 | 8'($urandom_range(0, 15)));
      end
      1: begin
        // fifth tag byte sets bits above 32
        add_cont_bytes(4);
        msg_bytes.push_back({1'($urandom), 7'($urandom_range(16, 127))});
      end
      2: begin
        // tenth value byte sets bits above 64
        add_tag(id, WT_VARINT);
        add_cont_bytes(9);
        msg_bytes.push_back({1'($urandom), 7'($urandom_range(2, 127))});
      end
      3: begin
        // value varint continues past 64 bits
        add_tag(id, WT_VARINT);
        add_cont_bytes(9);
        msg_bytes.push_back(8'h80 | 8'($urandom_range(0, 1)));
      end
      4: begin
        // length wider than its register
        add_tag(id, WT_BYTES);
        add_cont_bytes(4);
        msg_bytes.push_back({1'($urandom), 7'($urandom_range(16, 127))});
      end
      5: begin
        // zero byte after a continuation
        add_tag(id, WT_VARINT);
        add_cont_bytes(1);
        msg_bytes.push_back(8'h00);
      end
      default: begin
        // length promises more than the message holds
        add_tag(id, WT_BYTES);
        add_varint(64'($urandom_range(25, 32'hFFFF_FFFF)));
      end
    endcase
  endtask

  // mostly well-formed messages, some cut short or broken, a few pure noise
  task automatic make_msg();
    int unsigned sel;
    int unsigned n;
    int unsigned i;
    sel = $urandom_range(0, 99);
    if (sel >= 92) begin
      add_random_bytes($urandom_range(1, 8));
    end else begin
      n = $urandom_range(1, 4);
      for (i = 0; i < n; i++) add_field();
      if (sel >= 80) begin
        add_broken();
        add_random_bytes($urandom_range(0, 3));
      end else if (sel >= 72) begin
        n = $urandom_range(1, msg_bytes.size());
        msg_bytes = msg_bytes[0:n-1];
      end
    end
    send_msg();
  endtask

  initial begin
    int ks;
    int start;
    rst        = 1'b1;
    msg_valid  = 1'b0;
    msg_beat   = '0;
    cfg_we     = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    quiet      = 1'b0;
    bytes_sent = 0;
    msgs_sent  = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    for (ks = 0; ks < KEY_SETS; ks++) begin
      case (ks)
        0: keys_now = '{1, 2, 15, 16};
        1: keys_now = '{0, 0, 0, 0};
        // duplicates: the lowest index has to win
        2: keys_now = '{KEY_MAX, KEY_MAX, 1, KEY_MAX - 1};
        4: keys_now = '{5, 5, 5, 5};
        default: begin
          for (int i = 0; i < NUM_CFG_REGS; i++)
            keys_now[i] = $urandom_range(0, 1) ? KEY_ID_BITS'($urandom_range(1, 40))
                                               : KEY_ID_BITS'($urandom);
        end
      endcase
      write_keys();
      // one whole key setting runs with neither side idling
      quiet <= (ks == 3);
      start = bytes_sent;

      if (ks == 0) begin
        // largest 64-bit varint for key 0, then message done
        msg_bytes = '{8'h08, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                      8'h01};
        send_msg();
        // tag overflow, and the trailing byte swallowed by the error hold
        msg_bytes = '{8'h80, 8'h80, 8'h80, 8'h80, 8'h10, 8'h55};
        send_msg();
        // zero continuation byte inside the tag
        msg_bytes = '{8'h80, 8'h00};
        send_msg();
        // unknown wire type on a matching id
        msg_bytes = '{8'h0B};
        send_msg();
        // length then end of message inside the payload: two beats from one byte
        msg_bytes = '{8'h12, 8'h03};
        send_msg();
        // zero-length bytes field closing the message
        msg_bytes = '{8'h7A, 8'h00};
        send_msg();
      end

      while (bytes_sent - start < BYTES_PER_SET) make_msg();
      // every setting ends with the sender held off until all results are in
      drain();
    end

    $display("scanned %0d bytes in %0d messages under %0d key settings",
             bytes_sent, msgs_sent, KEY_SETS);
    $display("checked %0d values, %0d payload bytes, %0d message ends, %0d errors; %0d bad",
             n_value, n_payload, n_done, n_error, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+design
design/pbfs_pkg.sv
design/pbfs_decoder.sv
design/pbfs_result_fifo.sv
design/protobuf_field_scanner.sv
test/pbfs_monitor.sv
test/tb_top.sv
